/* rtl/pvma_pkg.sv */
`default_nettype none

package pvma_pkg;

    // item and bus widths
    localparam int OFF_W       = 14;
    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 18;
    localparam int PLANES      = 3;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 21;

    // mode register bit positions
    localparam int MODE_FILL_BIT  = 0;
    localparam int MODE_WSEL_LSB  = 1;
    localparam int MODE_RSEL_LSB  = 4;
    localparam int MODE_COLOR_BIT = 7;

    // access codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam logic REG_COLOR_MODE  = 1'b0;
    localparam logic REG_ACCESS_PAGE = 1'b1;

    // access sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_RD,
        ST_MOD
    } state_t;

    // clear the masked bits and set them where the fill asks
    function automatic logic [BYTE_W-1:0] merge_byte(
        input logic [BYTE_W-1:0] old_byte,
        input logic [BYTE_W-1:0] mask,
        input logic              fill
    );
        logic [BYTE_W-1:0] fill_byte;
        fill_byte = fill ? mask : '0;
        return (old_byte & ~mask) | fill_byte;
    endfunction

    // combine the three plane bytes into one read byte
    function automatic logic [BYTE_W-1:0] read_combine(
        input logic [BYTE_W-1:0] mode,
        input logic [BYTE_W-1:0] p0,
        input logic [BYTE_W-1:0] p1,
        input logic [BYTE_W-1:0] p2
    );
        logic [BYTE_W-1:0] q0;
        logic [BYTE_W-1:0] q1;
        logic [BYTE_W-1:0] q2;
        logic [BYTE_W-1:0] res;
        res = '0;
        if (mode[MODE_COLOR_BIT])
        begin
            q0  = mode[MODE_RSEL_LSB]     ? p0 : ~p0;
            q1  = mode[MODE_RSEL_LSB + 1] ? p1 : ~p1;
            q2  = mode[MODE_RSEL_LSB + 2] ? p2 : ~p2;
            res = ~(q0 & q1 & q2);
        end
        else
        begin
            if (mode[MODE_RSEL_LSB])
                res = res | p0;
            if (mode[MODE_RSEL_LSB + 1])
                res = res | p1;
            if (mode[MODE_RSEL_LSB + 2])
                res = res | p2;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/planar_video_memory_access_core.sv */
`default_nettype none

// Access unit for a three-plane bitmap video memory of PAGE_COUNT pages.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 colour/plane mode register, 1 access page); write only while idle.
// Input channel (in_valid/in_ready) carries one access beat: cmd, byte_offset
// and write_mask. A write beat gives no output; a read beat gives one
// read_data beat on the output channel (out_valid/out_ready).
// Each beat runs through a sequence of steps: offset wrap by reciprocal
// multiply, address sum, plane memory read, then merge and write-back or
// read combine. A new input beat is taken only once the previous beat has
// finished that read-modify-write sequence on the single port of each plane memory.
// A finished read waits in the output register; the next input beat is
// taken meanwhile, and its own result holds in the merge step until the
// output register is free.
// Reset clears the mode register, the page and the sequencer; plane memory
// contents are undefined until written and need no clearing.

module planar_video_memory_access_core #(
    parameter int PLANE_BYTES = 16384,
    parameter int PAGE_COUNT  = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [0:0]                         cfg_index,
    input  wire logic [pvma_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd,
    input  wire logic [pvma_pkg::OFF_W-1:0]         byte_offset,
    input  wire logic [pvma_pkg::BYTE_W-1:0]        write_mask,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [pvma_pkg::BYTE_W-1:0]        read_data
);

    localparam int DEPTH  = PAGE_COUNT * PLANE_BYTES;
    localparam int AW     = $clog2(DEPTH);
    localparam int BYTE_W = pvma_pkg::BYTE_W;
    localparam int PLANES = pvma_pkg::PLANES;

    pvma_pkg::state_t  state_reg;
    pvma_pkg::state_t  state_next;

    logic [BYTE_W-1:0] color_mode_reg;
    logic [1:0]        access_page_reg;
    logic              cmd_reg;
    logic [BYTE_W-1:0] mask_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_data_reg;

    logic              accept;
    logic              ram_re;
    logic              wb_en;
    logic              out_load;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] plane_rdata [PLANES];
    logic [BYTE_W-1:0] plane_wdata [PLANES];
    logic              plane_we    [PLANES];
    logic [BYTE_W-1:0] read_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg  <= '0;
            access_page_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pvma_pkg::REG_COLOR_MODE:  color_mode_reg  <= cfg_data;
                pvma_pkg::REG_ACCESS_PAGE: access_page_reg <= cfg_data[1:0];
                default:                   color_mode_reg  <= color_mode_reg;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pvma_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvma_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pvma_pkg::ST_DIV;
            pvma_pkg::ST_DIV:  state_next = pvma_pkg::ST_ADDR;
            pvma_pkg::ST_ADDR: state_next = pvma_pkg::ST_RD;
            pvma_pkg::ST_RD:   state_next = pvma_pkg::ST_MOD;
            pvma_pkg::ST_MOD:
                if (cmd_reg == pvma_pkg::CMD_WRITE || !out_valid_reg || out_ready)
                    state_next = pvma_pkg::ST_IDLE;
            default:           state_next = pvma_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        ram_re   = 1'b0;
        wb_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            pvma_pkg::ST_IDLE: in_ready = 1'b1;
            pvma_pkg::ST_RD:   ram_re   = 1'b1;
            pvma_pkg::ST_MOD:
            begin
                wb_en    = (cmd_reg == pvma_pkg::CMD_WRITE);
                out_load = (cmd_reg == pvma_pkg::CMD_READ) &&
                           (!out_valid_reg || out_ready);
            end
            default:           in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    // latch the access beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            mask_reg <= write_mask;
        end
    end

    // entry address from page and offset
    pvma_addr #(
        .PLANE_BYTES (PLANE_BYTES),
        .PAGE_COUNT  (PAGE_COUNT),
        .AW          (AW)
    ) u_addr (
        .clk    (clk),
        .start  (accept),
        .offset (byte_offset),
        .page   (access_page_reg),
        .addr   (addr)
    );

    // write-back data and enables per plane
    always_comb
    begin
        for (int k = 0; k < PLANES; k++)
        begin
            if (color_mode_reg[pvma_pkg::MODE_COLOR_BIT])
            begin
                plane_we[k]    = wb_en;
                plane_wdata[k] = pvma_pkg::merge_byte(plane_rdata[k], mask_reg,
                                     color_mode_reg[pvma_pkg::MODE_WSEL_LSB + k]);
            end
            else
            begin
                plane_we[k]    = wb_en && !color_mode_reg[pvma_pkg::MODE_WSEL_LSB + k];
                plane_wdata[k] = pvma_pkg::merge_byte(plane_rdata[k], mask_reg,
                                     color_mode_reg[pvma_pkg::MODE_FILL_BIT]);
            end
        end
    end

    // plane memories
    for (genvar g = 0; g < PLANES; g++)
    begin : g_plane
        pvma_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (plane_we[g]),
            .re    (ram_re),
            .addr  (addr),
            .wdata (plane_wdata[g]),
            .rdata (plane_rdata[g])
        );
    end

    assign read_byte = pvma_pkg::read_combine(color_mode_reg, plane_rdata[0],
                                              plane_rdata[1], plane_rdata[2]);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            read_data_reg <= read_byte;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

/* rtl/pvma_ram.sv */
`default_nettype none

module pvma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/pvma_addr.sv */
`default_nettype none

module pvma_addr #(
    parameter int PLANE_BYTES = 16384,
    parameter int PAGE_COUNT  = 4,
    parameter int AW          = 16
) (
    input  wire logic                        clk,
    input  wire logic                        start,
    input  wire logic [pvma_pkg::OFF_W-1:0]  offset,
    input  wire logic [1:0]                  page,
    output logic      [AW-1:0]               addr
);

    localparam int OFF_W  = pvma_pkg::OFF_W;
    localparam int SUM_W  = pvma_pkg::SUM_W;
    localparam int RW     = pvma_pkg::RECIP_W;
    localparam int SH     = pvma_pkg::RECIP_SHIFT;
    localparam int PROD_W = RW + OFF_W;
    localparam int Q_W    = PROD_W - SH;
    localparam logic [63:0] RECIP64 = (64'd1 << SH) / PLANE_BYTES + 64'd1;
    localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

    logic [OFF_W-1:0]  off_reg;
    logic [SUM_W-1:0]  base_reg;
    logic [Q_W-1:0]    q_reg;
    logic [AW-1:0]     addr_reg;

    logic [2:0]        page_mod;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  q_times_p;
    logic [SUM_W-1:0]  rem_full;
    logic [SUM_W-1:0]  addr_full;

    // page wraps over the page count
    always_comb
    begin
        page_mod = {1'b0, page};
        for (int i = 0; i < 3; i++)
        begin
            if (page_mod >= 3'(PAGE_COUNT))
                page_mod = page_mod - 3'(PAGE_COUNT);
        end
    end

    // latch offset and page base on a new beat
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            off_reg  <= offset;
            base_reg <= SUM_W'(page_mod) * SUM_W'(PLANE_BYTES);
        end
    end

    // quotient by reciprocal, exact for a 14-bit offset
    assign prod = {{RW{1'b0}}, off_reg} * {{OFF_W{1'b0}}, RECIP};

    always_ff @(posedge clk)
    begin
        q_reg <= prod[PROD_W-1:SH];
    end

    // remainder and final entry address
    assign q_times_p = SUM_W'(q_reg) * SUM_W'(PLANE_BYTES);
    assign rem_full  = {{(SUM_W-OFF_W){1'b0}}, off_reg} - q_times_p;
    assign addr_full = base_reg + rem_full;

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_full[AW-1:0];
    end

    assign addr = addr_reg;

endmodule

`default_nettype wire
